>>> sv/touch_motion_accumulator_defines.svh
// Assertion macros for the touch motion accumulator.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TOUCH_MOTION_ACCUMULATOR_DEFINES_SVH
`define TOUCH_MOTION_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTH
`define TMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tma assertion failed");
`define TMA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tma assertion failed");
`else
`define TMA_ASSERT_IMP(lbl, ante, cons)
`define TMA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> sv/tma_pkg.sv
package tma_pkg;

  localparam int unsigned SENS_W      = 4;
  localparam int unsigned THR_W       = 8;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned DELTA_W     = 16;
  localparam int unsigned COUNT_W     = 3;
  localparam int unsigned STRENGTH_W  = 16;
  localparam int unsigned REPORT_W    = 8;
  localparam int unsigned COEF_W      = 23;
  localparam int unsigned PROD_W      = DELTA_W + COEF_W;
  localparam int unsigned RECIP_SHIFT = 21;
  localparam int unsigned IN_DATA_W   = 56;
  localparam int unsigned OUT_DATA_W  = 56;
  localparam int unsigned OUT_USER_W  = 2;

  // ceil(2^21 / 5): exact floor division by five for products below 2^19
  localparam logic [18:0] RECIP_FIFTH = 19'd419431;

  localparam logic [STRENGTH_W-1:0] CLICK_STRENGTH = 16'd200;
  localparam logic [COUNT_W-1:0]    ONE_FINGER     = 3'd1;

  localparam logic [SENS_W-1:0] SENS_RESET = 4'd5;
  localparam logic [THR_W-1:0]  THR_RESET  = 8'd2;

  typedef enum logic [0:0] {
    REG_SENSITIVITY    = 1'b0,
    REG_MOVE_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta_x;
    logic signed [DELTA_W-1:0] delta_y;
    logic [COUNT_W-1:0]        touch_count;
    logic [STRENGTH_W-1:0]     first_strength;
  } in_item_t;

  typedef struct packed {
    logic [DELTA_W-1:0]         step_x;
    logic [DELTA_W-1:0]         step_y;
    logic                       moved;
    logic                       single;
    logic                       press;
    logic signed [REPORT_W-1:0] report_x;
    logic signed [REPORT_W-1:0] report_y;
  } scaled_t;

  typedef struct packed {
    logic                       move_valid;
    logic signed [DELTA_W-1:0]  move_x;
    logic signed [DELTA_W-1:0]  move_y;
    logic                       button_event;
    logic                       button_down;
    logic                       report_valid;
    logic signed [REPORT_W-1:0] report_x;
    logic signed [REPORT_W-1:0] report_y;
  } result_t;

  // sensitivity times the reciprocal of five, computed from the sensitivity code
  function automatic logic [COEF_W-1:0] gain_coef(input logic [SENS_W-1:0] sens);
    gain_coef = COEF_W'(sens) * COEF_W'(RECIP_FIFTH);
  endfunction

endpackage

>>> sv/tma_scale.sv
module tma_scale (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  tma_pkg::in_item_t                   item,
  input  logic [tma_pkg::SENS_W-1:0]          sens,
  output logic                                scl_valid,
  input  logic                                scl_ready,
  output tma_pkg::scaled_t                    scl
);

  logic              scl_valid_r;
  logic              scl_valid_nxt;
  tma_pkg::scaled_t  scl_r;
  tma_pkg::scaled_t  scl_nxt;
  logic [tma_pkg::COEF_W-1:0] coef;
  logic              advance;

  function automatic logic [tma_pkg::DELTA_W-1:0] scale_axis(
    input logic signed [tma_pkg::DELTA_W-1:0] raw,
    input logic [tma_pkg::COEF_W-1:0]         k
  );
    logic [tma_pkg::DELTA_W-1:0] m;
    logic [tma_pkg::PROD_W-1:0]  p;
    logic [tma_pkg::DELTA_W-1:0] q;
    m = raw[tma_pkg::DELTA_W-1] ? (~raw + 16'd1) : raw;
    p = tma_pkg::PROD_W'(m) * tma_pkg::PROD_W'(k);
    q = p[tma_pkg::RECIP_SHIFT +: tma_pkg::DELTA_W];
    return raw[tma_pkg::DELTA_W-1] ? (~q + 16'd1) : q;
  endfunction

  function automatic logic signed [tma_pkg::REPORT_W-1:0] clamp8(
    input logic signed [tma_pkg::DELTA_W-1:0] v
  );
    if (v > 16'sd127) begin
      return 8'sd127;
    end else if (v < -16'sd128) begin
      return -8'sd128;
    end
    return v[tma_pkg::REPORT_W-1:0];
  endfunction

  assign advance    = !scl_valid_r || scl_ready;
  assign item_ready = advance;
  assign coef       = tma_pkg::gain_coef(sens);

  always_comb begin
    scl_nxt.moved    = (item.delta_x != '0) || (item.delta_y != '0);
    scl_nxt.step_x   = scale_axis(item.delta_x, coef);
    scl_nxt.step_y   = scale_axis(item.delta_y, coef);
    scl_nxt.single   = (item.touch_count == tma_pkg::ONE_FINGER);
    scl_nxt.press    = (item.first_strength > tma_pkg::CLICK_STRENGTH);
    scl_nxt.report_x = scl_nxt.moved ? clamp8(item.delta_x) : '0;
    scl_nxt.report_y = scl_nxt.moved ? clamp8(item.delta_y) : '0;
    scl_valid_nxt    = advance ? item_valid : scl_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scl_valid_r <= 1'b0;
    end else begin
      scl_valid_r <= scl_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      scl_r <= scl_nxt;
    end
  end

  assign scl_valid = scl_valid_r;
  assign scl       = scl_r;

endmodule

>>> sv/tma_accum.sv
`include "touch_motion_accumulator_defines.svh"

module tma_accum (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        scl_valid,
  output logic                        scl_ready,
  input  tma_pkg::scaled_t            scl,
  input  logic [tma_pkg::THR_W-1:0]   thr,
  output logic                        res_valid,
  input  logic                        res_ready,
  output tma_pkg::result_t            res
);

  logic [tma_pkg::DELTA_W-1:0] sum_x_r, sum_x_nxt;
  logic [tma_pkg::DELTA_W-1:0] sum_y_r, sum_y_nxt;
  logic                        left_r, left_nxt;
  logic                        res_valid_r, res_valid_nxt;
  tma_pkg::result_t            res_r, res_nxt;
  logic [tma_pkg::DELTA_W-1:0] acc_x, acc_y;
  logic [tma_pkg::DELTA_W-1:0] mag_x, mag_y;
  logic                        hit_x, hit_y;
  logic                        advance;
  logic                        take;

  assign advance   = !res_valid_r || res_ready;
  assign scl_ready = advance;
  assign take      = advance && scl_valid;

  always_comb begin
    acc_x = sum_x_r + scl.step_x;
    acc_y = sum_y_r + scl.step_y;
    mag_x = acc_x[tma_pkg::DELTA_W-1] ? (~acc_x + 16'd1) : acc_x;
    mag_y = acc_y[tma_pkg::DELTA_W-1] ? (~acc_y + 16'd1) : acc_y;
    hit_x = scl.moved && (mag_x >= tma_pkg::DELTA_W'(thr));
    hit_y = scl.moved && (mag_y >= tma_pkg::DELTA_W'(thr));

    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    if (scl.moved) begin
      sum_x_nxt = hit_x ? '0 : acc_x;
      sum_y_nxt = hit_y ? '0 : acc_y;
    end

    left_nxt = scl.single ? scl.press : left_r;

    res_nxt.move_x       = hit_x ? acc_x : '0;
    res_nxt.move_y       = hit_y ? acc_y : '0;
    res_nxt.move_valid   = (res_nxt.move_x != '0) || (res_nxt.move_y != '0);
    res_nxt.button_event = scl.single && (scl.press != left_r);
    res_nxt.button_down  = left_nxt;
    res_nxt.report_valid = scl.moved;
    res_nxt.report_x     = scl.report_x;
    res_nxt.report_y     = scl.report_y;

    res_valid_nxt = advance ? scl_valid : res_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      left_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (take) begin
        sum_x_r <= sum_x_nxt;
        sum_y_r <= sum_y_nxt;
        left_r  <= left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  `TMA_ASSERT_NXT(a_still_sums, take && !scl.moved, $stable(sum_x_r) && $stable(sum_y_r))
  `TMA_ASSERT_NXT(a_keep_button, take && !scl.single, $stable(left_r))
  `TMA_ASSERT_NXT(a_clear_x, take, res_r.move_x == '0 || sum_x_r == '0)
  `TMA_ASSERT_NXT(a_clear_y, take, res_r.move_y == '0 || sum_y_r == '0)
  `TMA_ASSERT_NXT(a_button_state, take, res_r.button_down == left_r)

endmodule

>>> sv/touch_motion_accumulator.sv
// Each transaction passes through the input, scale and result registers in turn.
// Throughput: one transaction per cycle while out_tready is high; ready is chained through the
// stages, so input is still taken while a result waits if the input or scale register is empty.
// Reset (rst_n low, synchronous): clears all valid flags, both accumulators and the button state,
// and loads sensitivity 5 and move threshold 2.
module touch_motion_accumulator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] delta_x, [31:16] delta_y, [34:32] touch_count, [50:35] first_strength
  input  logic [tma_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] move_x, [31:16] move_y, [32] button_event, [33] button_down,
  // [41:34] report_x, [49:42] report_y
  output logic [tma_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [0] move_valid, [1] report_valid
  output logic [tma_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [tma_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic                              in_valid_r, in_valid_nxt;
  tma_pkg::in_item_t                 in_r, in_nxt;
  logic [tma_pkg::SENS_W-1:0]        sens_r;
  logic [tma_pkg::THR_W-1:0]         thr_r;
  logic                              item_ready;
  logic                              scl_valid, scl_ready;
  tma_pkg::scaled_t                  scl;
  tma_pkg::result_t                  res;
  logic                              take_in;

  assign in_tready = !in_valid_r || item_ready;
  assign take_in   = in_tvalid && in_tready;

  always_comb begin
    in_nxt.delta_x        = in_tdata[15:0];
    in_nxt.delta_y        = in_tdata[31:16];
    in_nxt.touch_count    = in_tdata[34:32];
    in_nxt.first_strength = in_tdata[50:35];
    in_valid_nxt          = in_tready ? in_tvalid : in_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      sens_r     <= tma_pkg::SENS_RESET;
      thr_r      <= tma_pkg::THR_RESET;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          tma_pkg::REG_SENSITIVITY:    sens_r <= cfg_wdata[tma_pkg::SENS_W-1:0];
          tma_pkg::REG_MOVE_THRESHOLD: thr_r  <= cfg_wdata[tma_pkg::THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      in_r <= in_nxt;
    end
  end

  tma_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_valid_r),
    .item_ready (item_ready),
    .item       (in_r),
    .sens       (sens_r),
    .scl_valid  (scl_valid),
    .scl_ready  (scl_ready),
    .scl        (scl)
  );

  tma_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .scl_valid (scl_valid),
    .scl_ready (scl_ready),
    .scl       (scl),
    .thr       (thr_r),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {6'd0, res.report_y, res.report_x, res.button_down, res.button_event,
                      res.move_y, res.move_x};
  assign out_tuser = {res.report_valid, res.move_valid};

endmodule

>>> tb/sv/motion_report_checker.sv
`timescale 1ns / 100ps
module motion_report_checker
  import tma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // [15:0] delta_x, [31:16] delta_y, [34:32] touch_count, [50:35] first_strength
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] move_x, [31:16] move_y, [32] button_event, [33] button_down,
  // [41:34] report_x, [49:42] report_y
  input  logic [OUT_DATA_W-1:0] out_tdata,
  // [0] move_valid, [1] report_valid
  input  logic [OUT_USER_W-1:0] out_tuser,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    reports_pending,
  output int                    report_errors
);

  localparam int GAIN_DIVISOR = 5;

  result_t            expected_reports[$];
  logic [SENS_W-1:0]  gain;
  logic [THR_W-1:0]   threshold;
  logic [DELTA_W-1:0] acc_x;
  logic [DELTA_W-1:0] acc_y;
  logic               button_held;
  in_item_t           rpt;
  result_t            got;
  result_t            want;

  function automatic logic [DELTA_W-1:0] scale_delta(logic signed [DELTA_W-1:0] raw);
    int product;
    product = int'(raw) * int'(gain);
    return DELTA_W'(product / GAIN_DIVISOR);
  endfunction

  function automatic int magnitude(logic [DELTA_W-1:0] v);
    int s;
    s = int'($signed(v));
    return (s < 0) ? -s : s;
  endfunction

  function automatic logic signed [REPORT_W-1:0] clamp_report(logic signed [DELTA_W-1:0] v);
    logic signed [REPORT_W-1:0] c;
    if (v > 127) c = 8'sd127;
    else if (v < -128) c = -8'sd128;
    else c = REPORT_W'(v);
    return c;
  endfunction

  function automatic result_t predict_report(in_item_t r);
    result_t res;
    logic    moved;
    logic    press;
    res = '0;
    moved = (r.delta_x != 0) || (r.delta_y != 0);
    if (moved) begin
      acc_x = acc_x + scale_delta(r.delta_x);
      acc_y = acc_y + scale_delta(r.delta_y);
      if (magnitude(acc_x) >= int'(threshold)) begin
        res.move_x = acc_x;
        acc_x = '0;
      end
      if (magnitude(acc_y) >= int'(threshold)) begin
        res.move_y = acc_y;
        acc_y = '0;
      end
      res.report_x = clamp_report(r.delta_x);
      res.report_y = clamp_report(r.delta_y);
    end
    if (r.touch_count == ONE_FINGER) begin
      press = r.first_strength > CLICK_STRENGTH;
      if (press != button_held) begin
        button_held = press;
        res.button_event = 1'b1;
      end
    end
    res.move_valid = (res.move_x != 0) || (res.move_y != 0);
    res.button_down = button_held;
    res.report_valid = moved;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      gain = SENS_RESET;
      threshold = THR_RESET;
      acc_x = '0;
      acc_y = '0;
      button_held = 1'b0;
      report_errors = 0;
      expected_reports.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SENSITIVITY:    gain = cfg_wdata[SENS_W-1:0];
          REG_MOVE_THRESHOLD: threshold = cfg_wdata[THR_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.move_valid   = out_tuser[0];
        got.report_valid = out_tuser[1];
        got.move_x       = out_tdata[15:0];
        got.move_y       = out_tdata[31:16];
        got.button_event = out_tdata[32];
        got.button_down  = out_tdata[33];
        got.report_x     = out_tdata[41:34];
        got.report_y     = out_tdata[49:42];
        if (expected_reports.size() == 0) begin
          if (report_errors < 10)
            $display("mismatch: result transaction with none expected, move %0d/%0d",
                     got.move_x, got.move_y);
          report_errors++;
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            if (report_errors < 10) begin
              $display("mismatch: expected mv=%0d mx=%0d my=%0d be=%0d bd=%0d rv=%0d rx=%0d ry=%0d",
                       want.move_valid, want.move_x, want.move_y, want.button_event,
                       want.button_down, want.report_valid, want.report_x, want.report_y);
              $display("          actual   mv=%0d mx=%0d my=%0d be=%0d bd=%0d rv=%0d rx=%0d ry=%0d",
                       got.move_valid, got.move_x, got.move_y, got.button_event,
                       got.button_down, got.report_valid, got.report_x, got.report_y);
            end
            report_errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        rpt.delta_x        = in_tdata[15:0];
        rpt.delta_y        = in_tdata[31:16];
        rpt.touch_count    = in_tdata[34:32];
        rpt.first_strength = in_tdata[50:35];
        expected_reports.push_back(predict_report(rpt));
      end
    end
    reports_pending <= expected_reports.size();
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import tma_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_REPORTS = 1200;
  localparam int PHASES         = 9;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int       reports_pending;
  int       report_errors;
  int       cycle_count = 0;
  int       burst_left = 0;
  int       ready_mode = 0;
  int       mode_left = 0;
  logic [7:0] ready_pattern = 8'hff;

  always #5 clk = ~clk;

  touch_motion_accumulator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  motion_report_checker report_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .reports_pending (reports_pending),
    .report_errors   (report_errors)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stall pattern: pick a new random ready mode each time the mode counter runs out
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_pattern <= 8'($urandom);
      mode_left <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
      ready_pattern <= {ready_pattern[6:0], ready_pattern[7]};
    end
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ready_pattern[0];
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  function automatic in_item_t make_report(int dx, int dy, int fingers, int strength);
    in_item_t r;
    r.delta_x = DELTA_W'(dx);
    r.delta_y = DELTA_W'(dy);
    r.touch_count = COUNT_W'(fingers);
    r.first_strength = STRENGTH_W'(strength);
    return r;
  endfunction

  function automatic logic signed [DELTA_W-1:0] random_delta();
    logic signed [DELTA_W-1:0] d;
    case ($urandom_range(0, 9))
      0, 1:    d = '0;
      2, 3, 4: d = DELTA_W'(int'($urandom_range(0, 8)) - 4);
      5, 6, 7: d = DELTA_W'(int'($urandom_range(0, 600)) - 300);
      8:       d = DELTA_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0:       d = 16'sh7fff;
          1:       d = 16'sh8000;
          2:       d = '1;
          default: d = 16'sd1;
        endcase
      end
    endcase
    return d;
  endfunction

  function automatic in_item_t random_report();
    in_item_t r;
    r.delta_x = random_delta();
    r.delta_y = random_delta();
    if ($urandom_range(0, 9) == 0) begin
      r.delta_x = '0;
      r.delta_y = '0;
    end
    r.touch_count = ($urandom_range(0, 19) < 11) ? ONE_FINGER : COUNT_W'($urandom_range(0, 5));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r.first_strength = STRENGTH_W'($urandom_range(195, 205));
      4, 5, 6:    r.first_strength = STRENGTH_W'($urandom);
      default:    r.first_strength = STRENGTH_W'($urandom_range(0, 400));
    endcase
    return r;
  endfunction

  task automatic send_report(in_item_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'({r.first_strength, r.touch_count, r.delta_y, r.delta_x});
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_registers(logic [SENS_W-1:0] sens, logic [THR_W-1:0] thr);
    cfg_we <= 1'b1;
    cfg_index <= REG_SENSITIVITY;
    cfg_wdata <= {4'($urandom), sens};
    @(posedge clk);
    cfg_index <= REG_MOVE_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [SENS_W-1:0] sens;
    logic [THR_W-1:0]  thr;
    int                per_phase;
    per_phase = RANDOM_REPORTS / PHASES;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_report(make_report(0, 0, 1, 0));
    send_report(make_report(1, 0, 1, 201));
    send_report(make_report(1, 1, 1, 201));
    send_report(make_report(0, 0, 0, 0));
    send_report(make_report(32767, -32768, 2, 65535));
    send_report(make_report(-32768, 32767, 1, 200));
    send_report(make_report(-1, -1, 1, 65535));
    send_report(make_report(-1, 0, 3, 0));
    send_report(make_report(127, -128, 4, 201));
    send_report(make_report(128, -129, 5, 100));
    send_report(make_report(0, 5, 1, 0));
    send_report(make_report(300, -300, 1, 201));
    send_report(make_report(-32768, -32768, 1, 201));
    send_report(make_report(21845, -21846, 2, 43690));
    send_report(make_report(-21846, 21845, 5, 21845));
    send_report(make_report(2, -2, 1, 199));
    send_report(make_report(0, 0, 1, 65535));
    send_report(make_report(-32768, 0, 1, 0));

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        case (phase)
          1:       begin sens = 4'd0;  thr = 8'd0;   end
          2:       begin sens = 4'd15; thr = 8'd255; end
          3:       begin sens = 4'd1;  thr = 8'd0;   end
          4:       begin sens = 4'd10; thr = 8'd255; end
          5:       begin sens = 4'd11; thr = 8'd1;   end
          6:       begin sens = 4'd3;  thr = 8'd128; end
          7:       begin sens = 4'd7;  thr = 8'd8;   end
          default: begin sens = SENS_RESET; thr = THR_RESET; end
        endcase
        drain();
        set_registers(sens, thr);
      end
      for (int i = 0; i < per_phase; i++) begin
        if (i == per_phase / 2 && phase % 2 == 1) drain();
        send_report(random_report());
      end
    end

    drain();
    if (report_errors == 0 && reports_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
